FILE: rtl/core/imu_motion_orientation_classifier_macros.svh
// assertion macros used by the classifier top level
`ifndef IMU_MOTION_ORIENTATION_CLASSIFIER_MACROS_SVH
`define IMU_MOTION_ORIENTATION_CLASSIFIER_MACROS_SVH

// same-cycle implication, checked out of reset
`define IMOC_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("imoc check failed");

// next-cycle implication, checked out of reset
`define IMOC_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("imoc check failed");

`endif

FILE: rtl/core/imoc_pkg.sv
// shared types, constants and helpers of the motion classifier
package imoc_pkg;

    // register indexes of the configuration port
    localparam logic [2:0] REG_MOVE_LIMIT   = 3'd0;
    localparam logic [2:0] REG_SHAKE_LIMIT  = 3'd1;
    localparam logic [2:0] REG_ROTATE_LIMIT = 3'd2;
    localparam logic [2:0] REG_SPIN_LIMIT   = 3'd3;
    localparam logic [2:0] REG_ORIENT_LIMIT = 3'd4;
    localparam logic [2:0] REG_LOW_PCT      = 3'd5;
    localparam logic [2:0] REG_CRIT_PCT     = 3'd6;

    localparam logic [15:0] ONE_G = 16'd4096;
    localparam logic [4:0] NIGHT_START = 5'd22;
    localparam logic [4:0] NIGHT_END = 5'd6;
    localparam logic [2:0] SUNDAY = 3'd0;
    localparam logic [2:0] SATURDAY = 3'd6;

    // cordic datapath widths
    localparam int CW = 28;
    localparam int ZW = 26;
    localparam int ATAN_LEN = 24;
    localparam logic signed [ZW-1:0] HALF_TURN = 26'sd11796480;
    localparam logic [21:0] ATAN_TAB [ATAN_LEN] = '{
        22'd2949120, 22'd1740967, 22'd919879, 22'd466945, 22'd234379, 22'd117304,
        22'd58666, 22'd29335, 22'd14668, 22'd7334, 22'd3667, 22'd1833,
        22'd917, 22'd458, 22'd229, 22'd115, 22'd57, 22'd29,
        22'd14, 22'd7, 22'd4, 22'd2, 22'd1, 22'd0
    };

    localparam logic [12:0] PITCH_LIMIT = 13'd1440;
    localparam logic [12:0] ROLL_LIMIT = 13'd2880;

    typedef enum logic [2:0] {
        ORIENT_NONE       = 3'd0,
        ORIENT_FACE_UP    = 3'd1,
        ORIENT_FACE_DOWN  = 3'd2,
        ORIENT_PORTRAIT   = 3'd3,
        ORIENT_PORTRAIT_I = 3'd4,
        ORIENT_LAND_LEFT  = 3'd5,
        ORIENT_LAND_RIGHT = 3'd6
    } orient_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_ROOT,
        ST_ANGLE
    } back_state_t;

    typedef struct packed {
        logic [14:0] move_lim;
        logic [15:0] shake_lim;
        logic [15:0] rotate_lim;
        logic [15:0] spin_lim;
        logic [14:0] orient_lim;
        logic [6:0]  low_pct;
        logic [6:0]  crit_pct;
    } cfg_t;

    // one item between front and back
    typedef struct packed {
        logic [31:0]        asq;
        logic [31:0]        gsq;
        logic [31:0]        hsq;
        logic signed [15:0] ax;
        logic signed [15:0] ay;
        logic signed [15:0] az;
        orient_t            orient;
        logic [1:0]         batt_flags;
        logic [1:0]         time_flags;
    } entry_t;

    typedef struct packed {
        logic [15:0]        amag;
        logic [15:0]        gmag;
        logic               moving;
        logic               shaking;
        logic               rotating;
        logic               spinning;
        logic               idle;
        orient_t            orient;
        logic signed [11:0] pitch;
        logic signed [12:0] roll;
        logic [1:0]         batt_flags;
        logic [1:0]         time_flags;
    } result_t;

    // one digit step of the square root, returns {remainder, root}
    function automatic logic [63:0] root_step(input logic [31:0] s, input logic [31:0] r,
                                              input logic [31:0] b);
        logic [32:0] t;
        t = {1'b0, r} + {1'b0, b};
        if ({1'b0, s} >= t) begin
            return {s - t[31:0], (r >> 1) + b};
        end
        return {s, r >> 1};
    endfunction

    // round the root to nearest from the final remainder
    function automatic logic [16:0] root_round(input logic [31:0] s, input logic [31:0] r);
        return (s > r) ? 17'(r + 32'd1) : r[16:0];
    endfunction

endpackage

FILE: rtl/core/imoc_front.sv
// front part: squares, orientation, battery and calendar flags
module imoc_front import imoc_pkg::*; (
    input  logic               in_valid,
    output logic               in_ready,
    input  logic signed [15:0] accel_x,
    input  logic signed [15:0] accel_y,
    input  logic signed [15:0] accel_z,
    input  logic signed [15:0] gyro_x,
    input  logic signed [15:0] gyro_y,
    input  logic signed [15:0] gyro_z,
    input  logic [6:0]         battery_percent,
    input  logic [4:0]         hour_of_day,
    input  logic [2:0]         weekday,
    input  cfg_t               cfg,
    output logic               push,
    input  logic               push_ready,
    output entry_t             entry
);

    logic [31:0] sq_ax, sq_ay, sq_az, sq_gx, sq_gy, sq_gz;
    logic [16:0] bx, by, bz, ol;

    assign in_ready = push_ready;
    assign push = in_valid && push_ready;

    // squares are never negative, so the low 32 bits hold them
    assign sq_ax = 32'(accel_x * accel_x);
    assign sq_ay = 32'(accel_y * accel_y);
    assign sq_az = 32'(accel_z * accel_z);
    assign sq_gx = 32'(gyro_x * gyro_x);
    assign sq_gy = 32'(gyro_y * gyro_y);
    assign sq_gz = 32'(gyro_z * gyro_z);

    // absolute axis values
    assign bx = accel_x[15] ? 17'(-18'(accel_x)) : 17'(accel_x);
    assign by = accel_y[15] ? 17'(-18'(accel_y)) : 17'(accel_y);
    assign bz = accel_z[15] ? 17'(-18'(accel_z)) : 17'(accel_z);
    assign ol = 17'(cfg.orient_lim);

    always_comb begin
        entry.asq = sq_ax + sq_ay + sq_az;
        entry.gsq = sq_gx + sq_gy + sq_gz;
        entry.hsq = sq_ax + sq_ay;
        entry.ax = accel_x;
        entry.ay = accel_y;
        entry.az = accel_z;

        // dominant axis, z first, then y, then x
        if (bz > bx && bz > by && bz > ol) begin
            entry.orient = (accel_z > 16'sd0) ? ORIENT_FACE_UP : ORIENT_FACE_DOWN;
        end else if (by > bx && by > bz && by > ol) begin
            entry.orient = accel_y[15] ? ORIENT_PORTRAIT : ORIENT_PORTRAIT_I;
        end else if (bx > by && bx > bz && bx > ol) begin
            entry.orient = (accel_x > 16'sd0) ? ORIENT_LAND_LEFT : ORIENT_LAND_RIGHT;
        end else begin
            entry.orient = ORIENT_NONE;
        end

        entry.batt_flags = {battery_percent < cfg.crit_pct, battery_percent < cfg.low_pct};
        entry.time_flags = {weekday == SUNDAY || weekday == SATURDAY,
                            hour_of_day >= NIGHT_START || hour_of_day < NIGHT_END};
    end

endmodule

FILE: rtl/core/imoc_queue.sv
// two-entry queue between front and back
module imoc_queue import imoc_pkg::*; (
    input  logic   aclk,
    input  logic   aresetn,
    input  logic   push,
    output logic   push_ready,
    input  entry_t push_data,
    input  logic   pop,
    output logic   pop_valid,
    output entry_t pop_data
);

    entry_t     mem_reg [2];
    logic       wptr_reg, wptr_next;
    logic       rptr_reg, rptr_next;
    logic [1:0] count_reg, count_next;

    assign push_ready = (count_reg != 2'd2);
    assign pop_valid = (count_reg != 2'd0);
    assign pop_data = mem_reg[rptr_reg];

    // pointer and fill count
    always_comb begin
        wptr_next = wptr_reg ^ push;
        rptr_next = rptr_reg ^ pop;
        count_next = count_reg + 2'(push) - 2'(pop);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wptr_reg <= 1'b0;
            rptr_reg <= 1'b0;
            count_reg <= 2'd0;
        end else begin
            wptr_reg <= wptr_next;
            rptr_reg <= rptr_next;
            count_reg <= count_next;
        end
    end

    // storage
    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wptr_reg] <= push_data;
        end
    end

endmodule

FILE: rtl/core/imoc_cordic.sv
// vectoring cordic atan2 in 1/16 degree, one step a cycle
module imoc_cordic import imoc_pkg::*; #(
    parameter int ANGLE_ITERATIONS = 16
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               start,
    input  logic signed [17:0] y_in,
    input  logic signed [17:0] x_in,
    input  logic [12:0]        lim,
    output logic               done,
    output logic signed [12:0] angle
);

    localparam int ITER = (ANGLE_ITERATIONS < ATAN_LEN) ? ANGLE_ITERATIONS : ATAN_LEN;

    logic signed [CW-1:0] x_reg, x_next, y_reg, y_next;
    logic signed [ZW-1:0] z_reg, z_next;
    logic [4:0]           cnt_reg, cnt_next;
    logic                 run_reg, run_next;
    logic                 done_reg, done_next;
    logic                 zero_reg, zero_next;
    logic signed [CW-1:0] x0, y0, xs, ys;
    logic signed [ZW-1:0] step_a;
    logic [ZW-1:0]        zabs;
    logic [13:0]          q;
    logic [13:0]          qs;

    assign x0 = CW'(x_in) <<< 8;
    assign y0 = CW'(y_in) <<< 8;
    assign xs = x_reg >>> cnt_reg;
    assign ys = y_reg >>> cnt_reg;
    assign step_a = ZW'(ATAN_TAB[cnt_reg]);

    // load, then micro-rotate toward the x axis
    always_comb begin
        x_next = x_reg;
        y_next = y_reg;
        z_next = z_reg;
        cnt_next = cnt_reg;
        run_next = run_reg;
        done_next = done_reg;
        zero_next = zero_reg;
        if (start) begin
            zero_next = (x_in == 18'sd0) && (y_in == 18'sd0);
            cnt_next = 5'd0;
            run_next = 1'b1;
            done_next = 1'b0;
            if (x_in < 18'sd0) begin
                z_next = (y_in >= 18'sd0) ? HALF_TURN : -HALF_TURN;
                x_next = -x0;
                y_next = -y0;
            end else begin
                z_next = '0;
                x_next = x0;
                y_next = y0;
            end
        end else if (run_reg) begin
            if (y_reg > 0) begin
                x_next = x_reg + ys;
                y_next = y_reg - xs;
                z_next = z_reg + step_a;
            end else begin
                x_next = x_reg - ys;
                y_next = y_reg + xs;
                z_next = z_reg - step_a;
            end
            cnt_next = cnt_reg + 5'd1;
            if (cnt_reg == 5'(ITER - 1)) begin
                run_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            run_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg <= 5'd0;
        end else begin
            run_reg <= run_next;
            done_reg <= done_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        x_reg <= x_next;
        y_reg <= y_next;
        z_reg <= z_next;
        zero_reg <= zero_next;
    end

    // round half away from zero to 1/16 degree, then saturate
    assign zabs = z_reg[ZW-1] ? ZW'(-z_reg) : ZW'(z_reg);
    assign q = 14'((zabs + ZW'(2048)) >> 12);
    assign qs = (q > 14'(lim)) ? 14'(lim) : q;
    assign done = done_reg;
    assign angle = zero_reg ? 13'sd0 : (z_reg[ZW-1] ? 13'(-qs) : 13'(qs));

endmodule

FILE: rtl/core/imoc_back.sv
// back part: square roots, angles, limit compares and the output register
module imoc_back import imoc_pkg::*; #(
    parameter int ANGLE_ITERATIONS = 16
) (
    input  logic    aclk,
    input  logic    aresetn,
    input  cfg_t    cfg,
    input  logic    q_valid,
    output logic    q_pop,
    input  entry_t  q_data,
    output logic    res_valid,
    input  logic    res_ready,
    output result_t res
);

    back_state_t state_reg, state_next;
    entry_t      ent_reg, ent_next;
    logic [31:0] s_reg [3];
    logic [31:0] s_next [3];
    logic [31:0] r_reg [3];
    logic [31:0] r_next [3];
    logic [31:0] bit_reg, bit_next;
    logic [15:0] amag_reg, amag_next, gmag_reg, gmag_next;
    logic        res_valid_reg, res_valid_next;
    result_t     res_reg, res_next;
    logic        roll_start, pitch_start;
    logic        roll_done, pitch_done;
    logic signed [12:0] roll_angle, pitch_angle;
    logic signed [17:0] pitch_x;
    logic [63:0] st1, st2;
    logic [16:0] rnd [3];
    logic [15:0] dev;
    logic        moving, rotating;

    assign dev = (amag_reg >= ONE_G) ? amag_reg - ONE_G : ONE_G - amag_reg;
    assign moving = dev > 16'(cfg.move_lim);
    assign rotating = gmag_reg > cfg.rotate_lim;

    // roll runs during the roots, pitch waits for the horizontal length
    imoc_cordic #(.ANGLE_ITERATIONS(ANGLE_ITERATIONS)) u_roll (
        .aclk(aclk), .aresetn(aresetn), .start(roll_start),
        .y_in(18'(q_data.ax)), .x_in(18'(q_data.ay)), .lim(ROLL_LIMIT),
        .done(roll_done), .angle(roll_angle)
    );

    imoc_cordic #(.ANGLE_ITERATIONS(ANGLE_ITERATIONS)) u_pitch (
        .aclk(aclk), .aresetn(aresetn), .start(pitch_start),
        .y_in(18'(ent_reg.az)), .x_in(pitch_x), .lim(PITCH_LIMIT),
        .done(pitch_done), .angle(pitch_angle)
    );

    always_comb begin
        state_next = state_reg;
        ent_next = ent_reg;
        bit_next = bit_reg;
        amag_next = amag_reg;
        gmag_next = gmag_reg;
        res_valid_next = res_valid_reg;
        res_next = res_reg;
        q_pop = 1'b0;
        roll_start = 1'b0;
        pitch_start = 1'b0;
        pitch_x = '0;
        st1 = '0;
        st2 = '0;
        for (int i = 0; i < 3; i++) begin
            s_next[i] = s_reg[i];
            r_next[i] = r_reg[i];
            rnd[i] = '0;
        end

        // output register drains independently of the work
        if (res_valid_reg && res_ready) begin
            res_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE: begin
                if (q_valid) begin
                    q_pop = 1'b1;
                    roll_start = 1'b1;
                    ent_next = q_data;
                    s_next[0] = q_data.asq;
                    s_next[1] = q_data.gsq;
                    s_next[2] = q_data.hsq;
                    for (int i = 0; i < 3; i++) begin
                        r_next[i] = '0;
                    end
                    bit_next = 32'h4000_0000;
                    state_next = ST_ROOT;
                end
            end
            // two root digits per cycle in each of the three lanes
            ST_ROOT: begin
                for (int i = 0; i < 3; i++) begin
                    st1 = root_step(s_reg[i], r_reg[i], bit_reg);
                    st2 = root_step(st1[63:32], st1[31:0], bit_reg >> 2);
                    s_next[i] = st2[63:32];
                    r_next[i] = st2[31:0];
                    rnd[i] = root_round(st2[63:32], st2[31:0]);
                end
                bit_next = bit_reg >> 4;
                if (bit_reg == 32'd4) begin
                    amag_next = rnd[0][15:0];
                    gmag_next = rnd[1][15:0];
                    pitch_x = 18'(rnd[2]);
                    pitch_start = 1'b1;
                    state_next = ST_ANGLE;
                end
            end
            ST_ANGLE: begin
                if (roll_done && pitch_done && (!res_valid_reg || res_ready)) begin
                    res_valid_next = 1'b1;
                    res_next.amag = amag_reg;
                    res_next.gmag = gmag_reg;
                    res_next.moving = moving;
                    res_next.shaking = amag_reg > cfg.shake_lim;
                    res_next.rotating = rotating;
                    res_next.spinning = gmag_reg > cfg.spin_lim;
                    res_next.idle = !moving && !rotating;
                    res_next.orient = ent_reg.orient;
                    res_next.pitch = 12'(pitch_angle);
                    res_next.roll = roll_angle;
                    res_next.batt_flags = ent_reg.batt_flags;
                    res_next.time_flags = ent_reg.time_flags;
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            res_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            res_valid_reg <= res_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        ent_reg <= ent_next;
        bit_reg <= bit_next;
        amag_reg <= amag_next;
        gmag_reg <= gmag_next;
        res_reg <= res_next;
        for (int i = 0; i < 3; i++) begin
            s_reg[i] <= s_next[i];
            r_reg[i] <= r_next[i];
        end
    end

    assign res_valid = res_valid_reg;
    assign res = res_reg;

endmodule

FILE: rtl/core/imu_motion_orientation_classifier.sv
// top level of the imu motion and orientation classifier
// One sample in, one result out. The front squares the axes and classifies
// orientation, battery and calendar in the cycle of acceptance and writes a
// two-entry queue. The back takes one item at a time: three rounded square
// roots at two digits a cycle while the roll cordic runs, then the pitch
// cordic of ANGLE_ITERATIONS steps (capped at 24), one step a cycle. The
// back's time per item sets the sustained rate; the front keeps accepting
// while the queue has room and a finished result waits in the output
// register.
module imu_motion_orientation_classifier import imoc_pkg::*; #(
    parameter int ANGLE_ITERATIONS = 16
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         cfg_we,
    input  logic [2:0]   cfg_index,
    input  logic [15:0]  cfg_data,
    input  logic         s_tvalid,
    output logic         s_tready,
    // accel_x, accel_y, accel_z, gyro_x, gyro_y, gyro_z, battery_percent,
    // hour_of_day, weekday, zero pad
    input  logic [111:0] s_tdata,
    output logic         m_tvalid,
    input  logic         m_tready,
    // accel_norm, gyro_norm, moving, shaking, rotating, spinning,
    // idle, orientation, pitch_angle, roll_angle, battery_flags, time_flags, zero pad
    output logic [71:0]  m_tdata
);

    `include "imu_motion_orientation_classifier_macros.svh"

    cfg_t    cfg_reg, cfg_next;
    entry_t  f_entry, q_data;
    logic    f_push, q_ready, q_valid, q_pop;
    result_t res;

    // configuration registers
    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_we) begin
            unique case (cfg_index)
                REG_MOVE_LIMIT:   cfg_next.move_lim = cfg_data[14:0];
                REG_SHAKE_LIMIT:  cfg_next.shake_lim = cfg_data;
                REG_ROTATE_LIMIT: cfg_next.rotate_lim = cfg_data;
                REG_SPIN_LIMIT:   cfg_next.spin_lim = cfg_data;
                REG_ORIENT_LIMIT: cfg_next.orient_lim = cfg_data[14:0];
                REG_LOW_PCT:      cfg_next.low_pct = cfg_data[6:0];
                REG_CRIT_PCT:     cfg_next.crit_pct = cfg_data[6:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.move_lim <= 15'd1229;
            cfg_reg.shake_lim <= 16'd8192;
            cfg_reg.rotate_lim <= 16'd480;
            cfg_reg.spin_lim <= 16'd1600;
            cfg_reg.orient_lim <= 15'd2867;
            cfg_reg.low_pct <= 7'd20;
            cfg_reg.crit_pct <= 7'd5;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    imoc_front u_front (
        .in_valid(s_tvalid), .in_ready(s_tready),
        .accel_x(s_tdata[15:0]), .accel_y(s_tdata[31:16]), .accel_z(s_tdata[47:32]),
        .gyro_x(s_tdata[63:48]), .gyro_y(s_tdata[79:64]), .gyro_z(s_tdata[95:80]),
        .battery_percent(s_tdata[102:96]), .hour_of_day(s_tdata[107:103]),
        .weekday(s_tdata[110:108]), .cfg(cfg_reg),
        .push(f_push), .push_ready(q_ready), .entry(f_entry)
    );

    imoc_queue u_queue (
        .aclk(aclk), .aresetn(aresetn),
        .push(f_push), .push_ready(q_ready), .push_data(f_entry),
        .pop(q_pop), .pop_valid(q_valid), .pop_data(q_data)
    );

    imoc_back #(.ANGLE_ITERATIONS(ANGLE_ITERATIONS)) u_back (
        .aclk(aclk), .aresetn(aresetn), .cfg(cfg_reg),
        .q_valid(q_valid), .q_pop(q_pop), .q_data(q_data),
        .res_valid(m_tvalid), .res_ready(m_tready), .res(res)
    );

    // result packing
    assign m_tdata = {3'd0, res.time_flags, res.batt_flags, res.roll, res.pitch,
                      res.orient, res.idle, res.spinning, res.rotating, res.shaking,
                      res.moving, res.gmag, res.amag};

    `IMOC_ASSERT_NOW(a_pop_needs_item, q_pop, q_valid)
    `IMOC_ASSERT_NOW(a_idle_flag, m_tvalid, m_tdata[36] == !(m_tdata[32] || m_tdata[34]))
    `IMOC_ASSERT_NOW(a_orient_code, m_tvalid, m_tdata[39:37] != 3'd7)
    `IMOC_ASSERT_NEXT(a_push_lands, f_push, q_valid)

endmodule
